[hw/rtl/ptc_pkg.sv]
`timescale 1ns / 1ps

package ptc_pkg;

  // field widths
  localparam int LEVEL_W    = 8;
  localparam int THR_W      = 10;
  localparam int CFG_SIZE_W = 11;
  localparam int COUNT_W    = 21;
  localparam int CENTROID_W = 10;

  // configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_COLUMNS   = 2'd1;
  localparam logic [1:0] REG_ROWS      = 2'd2;

  // register reset values
  localparam logic [THR_W-1:0]      THRESH_RESET = 10'd700;
  localparam logic [CFG_SIZE_W-1:0] COLS_RESET   = 11'd640;
  localparam logic [CFG_SIZE_W-1:0] ROWS_RESET   = 11'd480;

  // bias added to the channel sum before the compare
  localparam logic [THR_W-1:0] LEVEL_BIAS = 10'd3;

  // result kinds
  localparam logic KIND_MASK     = 1'b0;
  localparam logic KIND_CENTROID = 1'b1;

  // front to back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  typedef struct packed {
    logic [LEVEL_W-1:0] blue_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] red_level;
  } pixel_t;

  typedef struct packed {
    logic                  result_kind;
    logic                  mask_white;
    logic                  object_found;
    logic [COUNT_W-1:0]    object_pixel_count;
    logic [CENTROID_W-1:0] centroid_column;
    logic [CENTROID_W-1:0] centroid_row;
    logic                  last_of_item;
  } result_t;

  // one classified pixel as handed from front to back
  typedef struct packed {
    logic mask_white;
    logic frame_end;
  } entry_t;

endpackage

[hw/rtl/ptc_front.sv]
`timescale 1ns / 1ps

module ptc_front
  import ptc_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int CNT_W       = 21,
  parameter int SUM_W       = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pixel_t                pixel,
  input  logic                  push,
  output logic                  full,
  input  logic [THR_W-1:0]      threshold,
  input  logic [CFG_SIZE_W-1:0] frame_columns,
  input  logic [CFG_SIZE_W-1:0] frame_rows,
  output logic                  q_push,
  output entry_t                q_entry,
  input  logic                  q_full,
  input  logic                  snap_release,
  output logic [CNT_W-1:0]      snap_cnt,
  output logic [SUM_W-1:0]      snap_csum,
  output logic [SUM_W-1:0]      snap_rsum
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int SZC_W = $clog2(MAX_COLUMNS + 1);
  localparam int SZR_W = $clog2(MAX_ROWS + 1);
  localparam int SZA_W = (SZC_W > SZR_W) ? SZC_W : SZR_W;
  localparam int SZ_W  = (SZA_W > CFG_SIZE_W) ? SZA_W : CFG_SIZE_W;

  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] csum_r;
  logic [SUM_W-1:0] rsum_r;
  logic             snap_valid_r;
  logic [CNT_W-1:0] snap_cnt_r;
  logic [SUM_W-1:0] snap_csum_r;
  logic [SUM_W-1:0] snap_rsum_r;

  logic [CNT_W-1:0] cnt_nxt;
  logic [SUM_W-1:0] csum_nxt;
  logic [SUM_W-1:0] rsum_nxt;
  logic [SZ_W-1:0]  col_cfg;
  logic [SZ_W-1:0]  row_cfg;
  logic [SZ_W-1:0]  cols;
  logic [SZ_W-1:0]  rows;
  logic [SZ_W-1:0]  col_inc;
  logic [SZ_W-1:0]  row_inc;
  logic [THR_W-1:0] level;
  logic             white;
  logic             row_wrap;
  logic             frame_end;
  logic             accept;

  // brightness classification
  assign level = THR_W'(pixel.blue_level) + THR_W'(pixel.green_level)
               + THR_W'(pixel.red_level) + LEVEL_BIAS;
  assign white = (level >= threshold);

  // frame size with zero and oversize clamped
  assign col_cfg = SZ_W'(frame_columns);
  assign row_cfg = SZ_W'(frame_rows);

  always_comb begin
    priority if (col_cfg == '0) begin
      cols = SZ_W'(1);
    end else if (col_cfg > SZ_W'(MAX_COLUMNS)) begin
      cols = SZ_W'(MAX_COLUMNS);
    end else begin
      cols = col_cfg;
    end
    priority if (row_cfg == '0) begin
      rows = SZ_W'(1);
    end else if (row_cfg > SZ_W'(MAX_ROWS)) begin
      rows = SZ_W'(MAX_ROWS);
    end else begin
      rows = row_cfg;
    end
  end

  // position in the frame
  assign col_inc   = SZ_W'(col_r) + SZ_W'(1);
  assign row_inc   = SZ_W'(row_r) + SZ_W'(1);
  assign row_wrap  = (row_inc >= rows);
  assign frame_end = row_wrap && (col_inc >= cols);

  // accumulators including the current pixel
  assign cnt_nxt  = white ? cnt_r + CNT_W'(1) : cnt_r;
  assign csum_nxt = white ? csum_r + SUM_W'(col_r) : csum_r;
  assign rsum_nxt = white ? rsum_r + SUM_W'(row_r) : rsum_r;

  // a frame end waits while the previous frame totals are still in use
  assign full    = q_full || (snap_valid_r && frame_end);
  assign accept  = push && !full;
  assign q_push  = accept;
  assign q_entry = '{mask_white: white, frame_end: frame_end};

  // counters and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      cnt_r        <= '0;
      csum_r       <= '0;
      rsum_r       <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      if (snap_release) begin
        snap_valid_r <= 1'b0;
      end
      if (accept) begin
        if (frame_end) begin
          col_r        <= '0;
          row_r        <= '0;
          cnt_r        <= '0;
          csum_r       <= '0;
          rsum_r       <= '0;
          snap_valid_r <= 1'b1;
        end else begin
          cnt_r  <= cnt_nxt;
          csum_r <= csum_nxt;
          rsum_r <= rsum_nxt;
          if (row_wrap) begin
            row_r <= '0;
            col_r <= col_inc[COL_W-1:0];
          end else begin
            row_r <= row_inc[ROW_W-1:0];
          end
        end
      end
    end
  end

  // frame totals held for the back end
  always_ff @(posedge clk) begin
    if (accept && frame_end) begin
      snap_cnt_r  <= cnt_nxt;
      snap_csum_r <= csum_nxt;
      snap_rsum_r <= rsum_nxt;
    end
  end

  assign snap_cnt  = snap_cnt_r;
  assign snap_csum = snap_csum_r;
  assign snap_rsum = snap_rsum_r;

endmodule

[hw/rtl/ptc_queue.sv]
`timescale 1ns / 1ps

module ptc_queue
  import ptc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t pop_entry,
  output logic   empty
);

  entry_t                 mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_PTR_W:0]   fill_r;
  logic                   do_push;
  logic                   do_pop;

  assign full      = (fill_r == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign empty     = (fill_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = mem_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + (QUEUE_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - (QUEUE_PTR_W + 1)'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[hw/rtl/ptc_div.sv]
`timescale 1ns / 1ps

module ptc_div #(
  parameter int DVS_W = 21,
  parameter int QUO_W = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DVS_W+QUO_W-1:0] dividend,
  input  logic [DVS_W-1:0]       divisor,
  output logic                   busy,
  output logic [QUO_W-1:0]       quotient
);

  localparam int W      = DVS_W + QUO_W;
  localparam int STEP_W = $clog2(QUO_W + 1);

  logic [W-1:0]      rem_r;
  logic [W-1:0]      dvs_r;
  logic [QUO_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;
  logic              take;

  // restoring division, one quotient bit per cycle from the top
  assign take     = (rem_r >= dvs_r);
  assign busy     = (step_r != '0);
  assign quotient = quo_r;

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (start) begin
      step_r <= STEP_W'(QUO_W);
    end else if (busy) begin
      step_r <= step_r - STEP_W'(1);
    end
  end

  // remainder, shifted divisor and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dvs_r <= W'(divisor) << (QUO_W - 1);
      quo_r <= '0;
    end else if (busy) begin
      if (take) begin
        rem_r <= rem_r - dvs_r;
      end
      dvs_r <= dvs_r >> 1;
      quo_r <= QUO_W'({quo_r, take});
    end
  end

endmodule

[hw/rtl/ptc_back.sv]
`timescale 1ns / 1ps

module ptc_back
  import ptc_pkg::*;
#(
  parameter int CNT_W = 21,
  parameter int IDX_W = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  entry_t                 q_entry,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  logic [CNT_W-1:0]       snap_cnt,
  input  logic [CNT_W+IDX_W-1:0] snap_csum,
  input  logic [CNT_W+IDX_W-1:0] snap_rsum,
  output logic                   snap_release,
  output result_t                out_result,
  output logic                   out_empty,
  input  logic                   out_pop
);

  localparam int SUM_W = CNT_W + IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COL_GO,
    S_COL_WAIT,
    S_ROW_GO,
    S_ROW_WAIT,
    S_EMIT
  } state_t;

  state_t           state_r;
  logic             out_valid_r;
  result_t          out_result_r;
  logic [IDX_W-1:0] ccol_r;

  logic             slot_free;
  logic             load_out;
  logic             div_start;
  logic             div_busy;
  logic [SUM_W-1:0] div_dividend;
  logic [IDX_W-1:0] div_quo;
  logic             found;
  result_t          mask_res;
  result_t          end_res;

  // shared divider for the column and row means
  ptc_div #(
    .DVS_W (CNT_W),
    .QUO_W (IDX_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (snap_cnt),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // control decode
  assign slot_free    = !out_valid_r || out_pop;
  assign q_pop        = (state_r == S_IDLE) && !q_empty && slot_free;
  assign div_start    = (state_r == S_COL_GO) || (state_r == S_ROW_GO);
  assign div_dividend = (state_r == S_COL_GO) ? snap_csum : snap_rsum;
  assign snap_release = (state_r == S_EMIT) && slot_free;

  // output register loads on a queue pop or the centroid emit
  assign load_out = q_pop || snap_release;

  // result words
  assign found = (snap_cnt != '0);

  always_comb begin
    mask_res                    = '0;
    mask_res.result_kind        = KIND_MASK;
    mask_res.mask_white         = q_entry.mask_white;
    mask_res.last_of_item       = !q_entry.frame_end;

    end_res                     = '0;
    end_res.result_kind         = KIND_CENTROID;
    end_res.object_found        = found;
    end_res.object_pixel_count  = COUNT_W'(snap_cnt);
    end_res.centroid_column     = found ? CENTROID_W'(ccol_r) : '0;
    end_res.centroid_row        = found ? CENTROID_W'(div_quo) : '0;
    end_res.last_of_item        = 1'b1;
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            out_result_r <= mask_res;
            if (q_entry.frame_end) begin
              state_r <= S_COL_GO;
            end
          end
        end
        S_COL_GO: begin
          state_r <= S_COL_WAIT;
        end
        S_COL_WAIT: begin
          if (!div_busy) begin
            ccol_r  <= div_quo;
            state_r <= S_ROW_GO;
          end
        end
        S_ROW_GO: begin
          state_r <= S_ROW_WAIT;
        end
        S_ROW_WAIT: begin
          if (!div_busy) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_result_r <= end_res;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_result = out_result_r;
  assign out_empty  = !out_valid_r;

endmodule

[hw/rtl/pixel_threshold_centroid_unit.sv]
`timescale 1ns / 1ps

// binary threshold and blob centroid over a column-major frame of bgr pixels
// input queue port: an in_pixel request is taken when in_push is high and in_full low
// result queue port: out_result holds the oldest result while out_empty is low,
//   out_pop takes it; each pixel gives one mask result, the last pixel of a
//   frame also gives a centroid result with count and mean column and row
// registers on the apb port: threshold at 0x0, columns at 0x4, rows at 0x8
// a mask result is registered in the queue, then in the output register, after its pixel is taken
// throughput: one pixel per cycle while results are popped; while the back end
//   computes the centroid after the last pixel of a frame it pops nothing,
//   the four-entry queue fills and in_full holds the input
// the centroid result follows its mask result through the col go, col wait,
//   row go, row wait and emit states of the back end; one divider
//   unit computes column then row mean, one quotient bit per cycle
// the last pixel of the next frame waits until the previous centroid is out
// when the receiver stalls, results back up through the output register and
//   queue, then in_full rises; nothing is dropped
// reset clears counters, sums, queue and registers (threshold 700, 640 x 480)

module pixel_threshold_centroid_unit
  import ptc_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pixel_t                in_pixel,
  input  logic                  in_push,
  output logic                  in_full,
  output result_t               out_result,
  output logic                  out_empty,
  input  logic                  out_pop,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int IDX_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CNT_W = $clog2(MAX_COLUMNS * MAX_ROWS + 1);
  localparam int SUM_W = CNT_W + IDX_W;

  logic [THR_W-1:0]      thr_r;
  logic [CFG_SIZE_W-1:0] cols_r;
  logic [CFG_SIZE_W-1:0] rows_r;

  logic                  cfg_wr;
  logic [1:0]            cfg_index;
  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_empty;
  entry_t                q_in;
  entry_t                q_out;
  logic                  snap_release;
  logic [CNT_W-1:0]      snap_cnt;
  logic [SUM_W-1:0]      snap_csum;
  logic [SUM_W-1:0]      snap_rsum;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_index  = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESH_RESET;
      cols_r <= COLS_RESET;
      rows_r <= ROWS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr_r  <= cfg_pwdata[THR_W-1:0];
        REG_COLUMNS:   cols_r <= cfg_pwdata[CFG_SIZE_W-1:0];
        REG_ROWS:      rows_r <= cfg_pwdata[CFG_SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_index)
      REG_THRESHOLD: cfg_prdata = APB_DATA_W'(thr_r);
      REG_COLUMNS:   cfg_prdata = APB_DATA_W'(cols_r);
      REG_ROWS:      cfg_prdata = APB_DATA_W'(rows_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // classifier and frame accumulators
  ptc_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .pixel         (in_pixel),
    .push          (in_push),
    .full          (in_full),
    .threshold     (thr_r),
    .frame_columns (cols_r),
    .frame_rows    (rows_r),
    .q_push        (q_push),
    .q_entry       (q_in),
    .q_full        (q_full),
    .snap_release  (snap_release),
    .snap_cnt      (snap_cnt),
    .snap_csum     (snap_csum),
    .snap_rsum     (snap_rsum)
  );

  // decoupling queue
  ptc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (q_out),
    .empty      (q_empty)
  );

  // result generation and centroid division
  ptc_back #(
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_entry      (q_out),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .snap_cnt     (snap_cnt),
    .snap_csum    (snap_csum),
    .snap_rsum    (snap_rsum),
    .snap_release (snap_release),
    .out_result   (out_result),
    .out_empty    (out_empty),
    .out_pop      (out_pop)
  );

endmodule
